>>> rtl/core/length_prefixed_name_table_matcher_top_assert.svh
// Assertion macros used by the checker file of the name table matcher.
`ifndef LENGTH_PREFIXED_NAME_TABLE_MATCHER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_NAME_TABLE_MATCHER_TOP_ASSERT_SVH

// Condition a in one cycle requires condition b in the same cycle.
`define LPNTM_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lpntm same-cycle check failed");

// Condition a in one cycle requires condition b in the following cycle.
`define LPNTM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lpntm next-cycle check failed");

`endif

>>> rtl/core/lpntm_pkg.sv
// Shared constants and types of the length-prefixed name table matcher.
package lpntm_pkg;

	// Longest query name that can still match
	localparam int LPNTM_MAX_NAME_LENGTH = 255;

	// Word kinds carried on the input tuser bit
	localparam logic CMD_QUERY = 1'b0;
	localparam logic CMD_TABLE = 1'b1;

	// One search result, found in the lowest bit
	typedef struct packed {
		logic [15:0] ordinal;
		logic        found;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> rtl/core/lpntm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpntm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 255,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, read every cycle (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/core/length_prefixed_name_table_matcher_top.sv
// Top level of the length-prefixed name table matcher.
//
// The block takes one word per clock on s_axis: a query word (tuser = 0) appends a byte to the
// query name, tlast closing it; a table word (tuser = 1) feeds the name table parser, which walks
// records of a length byte, name bytes and a little-endian 16-bit ordinal, skips the first record,
// and stops at a zero length byte or at the first matching record. On the table word with tlast
// the block delivers one result on m_axis, found in bit 0 and the ordinal in bits 16:1. Every
// word is taken without a wait state: the query bytes sit in a RAM whose read address follows the
// next name position, so the byte to compare is ready when the name byte arrives, and a two-entry
// output buffer lets input words keep flowing while a result waits for m_tready. s_tready drops
// only when both output entries are full. No clearing pass is needed after reset.
module length_prefixed_name_table_matcher_top
	import lpntm_pkg::*;
#(
	parameter int MAX_NAME_LENGTH = LPNTM_MAX_NAME_LENGTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // [7:0] data_byte
	input  logic                   s_tlast,  // last
	input  logic                   s_tuser,  // [0] command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // [0] found, [16:1] ordinal, zero padding above
);

	localparam int AW  = (MAX_NAME_LENGTH > 1) ? $clog2(MAX_NAME_LENGTH) : 1;
	localparam int QLW = $clog2(MAX_NAME_LENGTH + 2);
	localparam logic [QLW-1:0] QL_MAX  = QLW'(MAX_NAME_LENGTH);
	localparam logic [QLW-1:0] QL_OVER = QLW'(MAX_NAME_LENGTH + 1);
	localparam logic [7:0]     NP_MAX  = 8'(MAX_NAME_LENGTH);

	typedef enum logic [2:0] {
		PH_LENGTH,
		PH_NAME,
		PH_ORD_LO,
		PH_ORD_HI,
		PH_IDLE
	} phase_t;

	// Parser and query state
	phase_t         phase_q, phase_d;
	logic [QLW-1:0] query_len_q, query_len_d;
	logic           loading_q, loading_d;
	logic [7:0]     bytes_left_q, bytes_left_d;
	logic [7:0]     name_pos_q, name_pos_d;
	logic           first_seen_q, first_seen_d;
	logic           matching_q, matching_d;
	logic [7:0]     ord_low_q, ord_low_d;
	logic           hit_q, hit_d;
	logic [15:0]    hit_ord_q, hit_ord_d;

	// Query RAM ports and collision bypass
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     rd_data;
	logic           byp_q;
	logic [7:0]     byp_data_q;
	logic [7:0]     query_byte;

	// Output buffer
	logic           out_valid_q, skid_valid_q;
	result_t        out_q, skid_q;
	result_t        res;
	logic           res_valid;

	logic           accept;
	logic           pop;
	logic [QLW-1:0] ql_base;

	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign pop       = out_valid_q && m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_TDATA_W'(out_q);
	assign query_byte = byp_q ? byp_data_q : rd_data;

	// Start a new query unless one is still open
	assign ql_base = loading_q ? query_len_q : '0;
	assign wr_en   = accept && (s_tuser == CMD_QUERY) && (ql_base < QL_MAX);
	assign wr_addr = ql_base[AW-1:0];
	assign rd_addr = name_pos_d[AW-1:0];

	lpntm_ram #(
		.WIDTH(8),
		.DEPTH(MAX_NAME_LENGTH)
	) u_query_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(s_tdata),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Next state for one accepted word
	always_comb begin
		phase_d      = phase_q;
		query_len_d  = query_len_q;
		loading_d    = loading_q;
		bytes_left_d = bytes_left_q;
		name_pos_d   = name_pos_q;
		first_seen_d = first_seen_q;
		matching_d   = matching_q;
		ord_low_d    = ord_low_q;
		hit_d        = hit_q;
		hit_ord_d    = hit_ord_q;
		res_valid    = 1'b0;
		res          = '0;
		if (accept && s_tuser == CMD_QUERY) begin
			// Append the byte, or mark the query as too long
			query_len_d = (ql_base < QL_MAX) ? ql_base + QLW'(1) : QL_OVER;
			loading_d   = !s_tlast;
		end else if (accept) begin
			case (phase_q)
				PH_LENGTH: begin
					if (s_tdata == 8'd0) begin
						phase_d = PH_IDLE;
					end else begin
						matching_d = first_seen_q && (query_len_q != '0) &&
							(query_len_q <= QL_MAX) &&
							(9'(query_len_q) == {1'b0, s_tdata});
						first_seen_d = 1'b1;
						bytes_left_d = s_tdata;
						name_pos_d   = 8'd0;
						phase_d      = PH_NAME;
					end
				end
				PH_NAME: begin
					if (matching_q && ((name_pos_q >= NP_MAX) ||
						({1'b0, name_pos_q} >= 9'(query_len_q)) ||
						(query_byte != s_tdata))) begin
						matching_d = 1'b0;
					end
					name_pos_d   = name_pos_q + 8'd1;
					bytes_left_d = bytes_left_q - 8'd1;
					if (bytes_left_q == 8'd1) begin
						phase_d = PH_ORD_LO;
					end
				end
				PH_ORD_LO: begin
					ord_low_d = s_tdata;
					phase_d   = PH_ORD_HI;
				end
				PH_ORD_HI: begin
					if (matching_q) begin
						hit_d     = 1'b1;
						hit_ord_d = {s_tdata, ord_low_q};
						phase_d   = PH_IDLE;
					end else begin
						phase_d = PH_LENGTH;
					end
					matching_d = 1'b0;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
			// Report on the table's last word and rearm the parser
			if (s_tlast) begin
				res_valid    = 1'b1;
				res.found    = hit_d;
				res.ordinal  = hit_d ? hit_ord_d : 16'd0;
				phase_d      = PH_LENGTH;
				bytes_left_d = 8'd0;
				name_pos_d   = 8'd0;
				first_seen_d = 1'b0;
				matching_d   = 1'b0;
				ord_low_d    = 8'd0;
				hit_d        = 1'b0;
				hit_ord_d    = 16'd0;
			end
		end
	end

	// Hold parser state and the output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LENGTH;
			query_len_q  <= '0;
			loading_q    <= 1'b0;
			bytes_left_q <= 8'd0;
			name_pos_q   <= 8'd0;
			first_seen_q <= 1'b0;
			matching_q   <= 1'b0;
			ord_low_q    <= 8'd0;
			hit_q        <= 1'b0;
			hit_ord_q    <= 16'd0;
			byp_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			query_len_q  <= query_len_d;
			loading_q    <= loading_d;
			bytes_left_q <= bytes_left_d;
			name_pos_q   <= name_pos_d;
			first_seen_q <= first_seen_d;
			matching_q   <= matching_d;
			ord_low_q    <= ord_low_d;
			hit_q        <= hit_d;
			hit_ord_q    <= hit_ord_d;
			// Cover a write to the address being read this cycle
			byp_q        <= wr_en && (wr_addr == rd_addr);
			if (skid_valid_q) begin
				if (pop) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (!out_valid_q || pop) begin
				out_valid_q <= res_valid;
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers without reset
	always_ff @(posedge clk) begin
		byp_data_q <= s_tdata;
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			out_q <= res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

endmodule

>>> rtl/core/lpntm_checker.sv
// Port-level checker for the name table matcher, bound to the top level.
`include "length_prefixed_name_table_matcher_top_assert.svh"

module lpntm_checker
	import lpntm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [7:0]             s_tdata,  // [7:0] data_byte
	input logic                   s_tlast,  // last
	input logic                   s_tuser,  // [0] command
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata   // [0] found, [16:1] ordinal
);

	logic s_word;

	assign s_word = s_tvalid && s_tready;

	// A stalled result holds its value
	`LPNTM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))

	// A query word never produces a result
	`LPNTM_ASSERT_NEXT(a_query_silent, clk, arst_n,
		!m_tvalid && s_word && (s_tuser == CMD_QUERY), !m_tvalid)

	// A table word without tlast never produces a result
	`LPNTM_ASSERT_NEXT(a_table_mid_silent, clk, arst_n,
		!m_tvalid && s_word && (s_tuser == CMD_TABLE) && !s_tlast, !m_tvalid)

	// The last table word produces a result from the output register
	`LPNTM_ASSERT_NEXT(a_table_end_result, clk, arst_n,
		!m_tvalid && s_word && (s_tuser == CMD_TABLE) && s_tlast, m_tvalid)

endmodule

bind length_prefixed_name_table_matcher_top lpntm_checker u_lpntm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tlast (s_tlast),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
